[rtl/tdq_pkg.sv]
// Shared types, codes and helpers of the timer deadline queue.
package tdq_pkg;

  localparam int DL_W = 63;
  localparam int ID_W = 16;
  localparam int OP_W = 2;
  localparam int ST_W = 2;

  localparam logic [OP_W-1:0] OP_ADD = 2'd0;
  localparam logic [OP_W-1:0] OP_DEL = 2'd1;
  localparam logic [OP_W-1:0] OP_EXP = 2'd2;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_DUP       = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd2;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd3;

  localparam int POP_LIMIT = 16;
  localparam int POP_W     = $clog2(POP_LIMIT);
  localparam int POP_CNT_W = $clog2(POP_LIMIT + 1);

  typedef struct packed {
    logic [DL_W-1:0] dl;
    logic [ID_W-1:0] id;
  } entry_t;

  typedef struct packed {
    logic   min_found;
    entry_t min_key;
    logic   match_found;
    logic   free_found;
  } scan_t;

  function automatic logic key_less(entry_t a, entry_t b);
    return (a.dl < b.dl) || ((a.dl == b.dl) && (a.id < b.id));
  endfunction

endpackage

[rtl/timer_deadline_queue.sv]
// Top level of the timer deadline queue: sequencer, pop buffer and result register.
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+---------------------------------
//  request  | in_opcode in_timer_id in_deadline        | taken when start && !busy
//           | in_now_time                             |
//  result   | out_status out_expired_* out_last_result | out_valid for one cycle each,
//           | out_timer_count out_earliest_*          | never held off
//
// One pass over the entry memory goes through the single read port and the shared
// key comparator. Add and unused opcodes take one pass, delete one when the key is
// missing and two otherwise, expire one pass per popped timer plus one, then one
// result per cycle.
// busy stays high until the last result is registered; the next request may be
// taken in the cycle that result is shown. Reset empties the set at once.
module timer_deadline_queue #(
  parameter int CAPACITY = 16,
  localparam int IDX_W = $clog2(CAPACITY),
  localparam int CNT_W = $clog2(CAPACITY + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [tdq_pkg::OP_W-1:0]      in_opcode,
  input  logic [tdq_pkg::ID_W-1:0]      in_timer_id,
  input  logic [tdq_pkg::DL_W-1:0]      in_deadline,
  input  logic [tdq_pkg::DL_W-1:0]      in_now_time,
  output logic                          out_valid,
  output logic [tdq_pkg::ST_W-1:0]      out_status,
  output logic                          out_expired_valid,
  output logic [tdq_pkg::ID_W-1:0]      out_expired_id,
  output logic [tdq_pkg::DL_W-1:0]      out_expired_deadline,
  output logic                          out_last_result,
  output logic [CNT_W-1:0]              out_timer_count,
  output logic                          out_earliest_valid,
  output logic [tdq_pkg::DL_W-1:0]      out_earliest_deadline,
  output logic                          out_earliest_changed
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
  localparam logic [tdq_pkg::POP_CNT_W-1:0] POP_MAX = tdq_pkg::POP_CNT_W'(tdq_pkg::POP_LIMIT);

  logic [1:0]                         state_r, state_nxt;
  logic                               phase_r, phase_nxt;
  logic [tdq_pkg::OP_W-1:0]           op_r;
  tdq_pkg::entry_t                    key_r;
  logic [tdq_pkg::DL_W-1:0]           now_r;
  logic [CNT_W-1:0]                   scan_cnt_r, scan_cnt_nxt;
  logic [CNT_W-1:0]                   count_r, count_nxt;
  logic                               flag_r, flag_nxt;
  logic                               chg_cand_r, chg_cand_nxt;
  logic [tdq_pkg::POP_CNT_W-1:0]      n_r, n_nxt;
  logic [tdq_pkg::POP_W-1:0]          k_r, k_nxt;
  logic                               ev_r, ev_nxt;
  logic [tdq_pkg::DL_W-1:0]           edl_r, edl_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic [tdq_pkg::ST_W-1:0]           status_r, status_nxt;
  logic                               oev_r, oev_nxt;
  logic                               last_r, last_nxt;
  tdq_pkg::entry_t                    exp_r;

  tdq_pkg::entry_t                    pbuf [tdq_pkg::POP_LIMIT];

  logic                               accept;
  logic                               rd_en;
  logic                               rd_pend;
  logic [IDX_W-1:0]                   rd_slot;
  logic                               rd_valid;
  tdq_pkg::entry_t                    rd_entry;
  logic                               wr_en;
  logic                               clr_en;
  logic [IDX_W-1:0]                   clr_addr;
  logic                               scan_clr;
  logic                               scan_done;
  tdq_pkg::scan_t                     res;
  logic [IDX_W-1:0]                   min_slot;
  logic [IDX_W-1:0]                   match_slot;
  logic [IDX_W-1:0]                   free_slot;
  logic                               due;
  logic                               new_first;
  logic                               pop_wr;
  logic                               pop_rd;
  logic                               exp_zero;
  logic                               finish;
  logic [tdq_pkg::ST_W-1:0]           fin_status;
  logic                               emit_last;

  tdq_store #(.CAPACITY(CAPACITY)) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (rd_en),
    .rd_addr  (scan_cnt_r[IDX_W-1:0]),
    .rd_pend  (rd_pend),
    .rd_slot  (rd_slot),
    .rd_valid (rd_valid),
    .rd_entry (rd_entry),
    .wr_en    (wr_en),
    .wr_addr  (free_slot),
    .wr_entry (key_r),
    .clr_en   (clr_en),
    .clr_addr (clr_addr)
  );

  tdq_scan #(.CAPACITY(CAPACITY)) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .clr        (scan_clr),
    .elem_en    (rd_pend),
    .elem_slot  (rd_slot),
    .elem_valid (rd_valid),
    .elem       (rd_entry),
    .key        (key_r),
    .res        (res),
    .min_slot   (min_slot),
    .match_slot (match_slot),
    .free_slot  (free_slot)
  );

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && (state_r == S_IDLE);
  assign rd_en     = (state_r == S_SCAN) && (scan_cnt_r != CAP_CNT);
  assign scan_done = (state_r == S_SCAN) && (scan_cnt_r == CAP_CNT) && !rd_pend;
  assign due       = res.min_found && (res.min_key.dl <= now_r) && (n_r < POP_MAX);
  assign new_first = !res.min_found || tdq_pkg::key_less(key_r, res.min_key);
  assign emit_last = (tdq_pkg::POP_CNT_W'(k_r) == (n_r - tdq_pkg::POP_CNT_W'(1)));

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    scan_cnt_nxt  = scan_cnt_r;
    count_nxt     = count_r;
    flag_nxt      = flag_r;
    chg_cand_nxt  = chg_cand_r;
    n_nxt         = n_r;
    k_nxt         = k_r;
    ev_nxt        = ev_r;
    edl_nxt       = edl_r;
    out_valid_nxt = 1'b0;
    status_nxt    = status_r;
    oev_nxt       = oev_r;
    last_nxt      = last_r;
    scan_clr      = 1'b0;
    wr_en         = 1'b0;
    clr_en        = 1'b0;
    clr_addr      = match_slot;
    pop_wr        = 1'b0;
    pop_rd        = 1'b0;
    exp_zero      = 1'b0;
    finish        = 1'b0;
    fin_status    = tdq_pkg::ST_OK;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt    = S_SCAN;
          phase_nxt    = 1'b0;
          scan_cnt_nxt = '0;
          n_nxt        = '0;
          scan_clr     = 1'b1;
        end
      end
      S_SCAN: begin
        if (rd_en) begin
          scan_cnt_nxt = scan_cnt_r + CNT_W'(1);
        end
        if (scan_done) begin
          ev_nxt  = res.min_found;
          edl_nxt = res.min_found ? res.min_key.dl : '0;
          unique case (op_r)
            tdq_pkg::OP_ADD: begin
              finish = 1'b1;
              if (res.match_found) begin
                fin_status = tdq_pkg::ST_DUP;
              end else if (!res.free_found) begin
                fin_status = tdq_pkg::ST_FULL;
              end else begin
                wr_en     = 1'b1;
                count_nxt = count_r + CNT_W'(1);
                flag_nxt  = new_first;
                ev_nxt    = 1'b1;
                edl_nxt   = new_first ? key_r.dl : res.min_key.dl;
              end
            end
            tdq_pkg::OP_DEL: begin
              if (phase_r) begin
                if (res.min_found) begin
                  flag_nxt = chg_cand_r;
                end
                finish = 1'b1;
              end else if (!res.match_found) begin
                fin_status = tdq_pkg::ST_NOT_FOUND;
                finish     = 1'b1;
              end else begin
                clr_en       = 1'b1;
                count_nxt    = count_r - CNT_W'(1);
                chg_cand_nxt = (min_slot == match_slot);
                phase_nxt    = 1'b1;
                scan_cnt_nxt = '0;
                scan_clr     = 1'b1;
              end
            end
            tdq_pkg::OP_EXP: begin
              if (due) begin
                clr_en       = 1'b1;
                clr_addr     = min_slot;
                count_nxt    = count_r - CNT_W'(1);
                pop_wr       = 1'b1;
                n_nxt        = n_r + tdq_pkg::POP_CNT_W'(1);
                scan_cnt_nxt = '0;
                scan_clr     = 1'b1;
              end else if (n_r != '0) begin
                flag_nxt  = 1'b1;
                state_nxt = S_EMIT;
                k_nxt     = '0;
              end else begin
                finish = 1'b1;
              end
            end
            default: begin
              finish = 1'b1;
            end
          endcase
        end
      end
      S_EMIT: begin
        pop_rd        = 1'b1;
        out_valid_nxt = 1'b1;
        status_nxt    = tdq_pkg::ST_OK;
        oev_nxt       = 1'b1;
        last_nxt      = emit_last;
        k_nxt         = k_r + tdq_pkg::POP_W'(1);
        if (emit_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (finish) begin
      state_nxt     = S_IDLE;
      out_valid_nxt = 1'b1;
      status_nxt    = fin_status;
      oev_nxt       = 1'b0;
      last_nxt      = 1'b1;
      exp_zero      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      flag_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      flag_r      <= flag_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_opcode;
      key_r <= '{dl: in_deadline, id: in_timer_id};
      now_r <= in_now_time;
    end
    phase_r    <= phase_nxt;
    scan_cnt_r <= scan_cnt_nxt;
    chg_cand_r <= chg_cand_nxt;
    n_r        <= n_nxt;
    k_r        <= k_nxt;
    ev_r       <= ev_nxt;
    edl_r      <= edl_nxt;
    status_r   <= status_nxt;
    oev_r      <= oev_nxt;
    last_r     <= last_nxt;
  end

  always_ff @(posedge clk) begin
    if (pop_wr) begin
      pbuf[n_r[tdq_pkg::POP_W-1:0]] <= res.min_key;
    end
    if (pop_rd) begin
      exp_r <= pbuf[k_r];
    end else if (exp_zero) begin
      exp_r <= '0;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_status            = status_r;
  assign out_expired_valid     = oev_r;
  assign out_expired_id        = exp_r.id;
  assign out_expired_deadline  = exp_r.dl;
  assign out_last_result       = last_r;
  assign out_timer_count       = count_r;
  assign out_earliest_valid    = ev_r;
  assign out_earliest_deadline = edl_r;
  assign out_earliest_changed  = flag_r;

endmodule

[rtl/tdq_store.sv]
// Entry memory with per-slot valid bits and a registered read port.
module tdq_store #(
  parameter int CAPACITY = 16,
  localparam int IDX_W = $clog2(CAPACITY)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               rd_en,
  input  logic [IDX_W-1:0]   rd_addr,
  output logic               rd_pend,
  output logic [IDX_W-1:0]   rd_slot,
  output logic               rd_valid,
  output tdq_pkg::entry_t    rd_entry,
  input  logic               wr_en,
  input  logic [IDX_W-1:0]   wr_addr,
  input  tdq_pkg::entry_t    wr_entry,
  input  logic               clr_en,
  input  logic [IDX_W-1:0]   clr_addr
);

  tdq_pkg::entry_t mem [CAPACITY];
  logic [CAPACITY-1:0] valid_r;
  logic                rd_pend_r;
  logic [IDX_W-1:0]    rd_slot_r;
  logic                rd_valid_r;
  tdq_pkg::entry_t     rd_entry_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    if (rd_en) begin
      rd_entry_r <= mem[rd_addr];
      rd_slot_r  <= rd_addr;
      rd_valid_r <= valid_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      rd_pend_r <= 1'b0;
    end else begin
      rd_pend_r <= rd_en;
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (clr_en) begin
        valid_r[clr_addr] <= 1'b0;
      end
    end
  end

  assign rd_pend  = rd_pend_r;
  assign rd_slot  = rd_slot_r;
  assign rd_valid = rd_valid_r;
  assign rd_entry = rd_entry_r;

endmodule

[rtl/tdq_scan.sv]
// Shared key comparator that folds one entry per cycle into min, match and free results.
module tdq_scan #(
  parameter int CAPACITY = 16,
  localparam int IDX_W = $clog2(CAPACITY)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             clr,
  input  logic             elem_en,
  input  logic [IDX_W-1:0] elem_slot,
  input  logic             elem_valid,
  input  tdq_pkg::entry_t  elem,
  input  tdq_pkg::entry_t  key,
  output tdq_pkg::scan_t   res,
  output logic [IDX_W-1:0] min_slot,
  output logic [IDX_W-1:0] match_slot,
  output logic [IDX_W-1:0] free_slot
);

  logic             min_found_r;
  tdq_pkg::entry_t  min_key_r;
  logic             match_found_r;
  logic             free_found_r;
  logic [IDX_W-1:0] min_slot_r;
  logic [IDX_W-1:0] match_slot_r;
  logic [IDX_W-1:0] free_slot_r;
  logic             take_min;
  logic             take_match;
  logic             take_free;

  assign take_min   = elem_en && elem_valid &&
                      (!min_found_r || tdq_pkg::key_less(elem, min_key_r));
  assign take_match = elem_en && elem_valid && !match_found_r && (elem == key);
  assign take_free  = elem_en && !elem_valid && !free_found_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_found_r   <= 1'b0;
      match_found_r <= 1'b0;
      free_found_r  <= 1'b0;
    end else if (clr) begin
      min_found_r   <= 1'b0;
      match_found_r <= 1'b0;
      free_found_r  <= 1'b0;
    end else begin
      if (take_min) begin
        min_found_r <= 1'b1;
      end
      if (take_match) begin
        match_found_r <= 1'b1;
      end
      if (take_free) begin
        free_found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_min) begin
      min_key_r  <= elem;
      min_slot_r <= elem_slot;
    end
    if (take_match) begin
      match_slot_r <= elem_slot;
    end
    if (take_free) begin
      free_slot_r <= elem_slot;
    end
  end

  assign res        = '{min_found: min_found_r, min_key: min_key_r,
                        match_found: match_found_r, free_found: free_found_r};
  assign min_slot   = min_slot_r;
  assign match_slot = match_slot_r;
  assign free_slot  = free_slot_r;

endmodule

[rtl/tdq_checker.sv]
// Port-level checker for the timer deadline queue and its bind.
module tdq_checker #(
  parameter int CAPACITY = 16,
  localparam int CNT_W = $clog2(CAPACITY + 1)
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_valid,
  input logic                          out_expired_valid,
  input logic [tdq_pkg::DL_W-1:0]      out_expired_deadline,
  input logic                          out_last_result,
  input logic [CNT_W-1:0]              out_timer_count,
  input logic                          out_earliest_valid,
  input logic [tdq_pkg::DL_W-1:0]      out_earliest_deadline,
  input logic                          out_earliest_changed
);

  a_request_takes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted request did not raise busy");

  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a request in flight");

  a_burst_unbroken: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_result |=> out_valid && out_expired_valid)
    else $error("expired results not back to back");

  a_earliest_vs_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_earliest_valid == (out_timer_count != '0)))
    else $error("earliest valid disagrees with timer count");

  a_popped_not_later: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_expired_valid && out_earliest_valid |->
      out_expired_deadline <= out_earliest_deadline)
    else $error("popped timer later than a remaining one");

endmodule

bind timer_deadline_queue tdq_checker #(.CAPACITY(CAPACITY)) u_tdq_checker (.*);
